[rtl/ilst_pkg.sv]
`default_nettype none
package ilst_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int OP_W    = 3;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int FILL_W  = 7;

  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GRP_SZ  = 8;
  localparam int NUM_GRP = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [CMP_W-1:0]      cmp_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5,
    OP_CLEAR  = 3'd6,
    OP_NONE   = 3'd7
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_NEW   = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       rd_sel;
  } cell_ctrl_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0]  read_value;
    logic [ST_W-1:0]   status;
    logic [FILL_W-1:0] fill_count;
    logic              is_empty;
  } out_word_t;

  function automatic data_t to_data(input logic [VAL_W-1:0] v);
    data_t d;
    for (int b = 0; b < DATA_WIDTH; b++) begin
      d[b] = (b < VAL_W) ? v[b] : 1'b0;
    end
    return d;
  endfunction

  function automatic logic [VAL_W-1:0] from_data(input data_t d);
    logic [VAL_W-1:0] v;
    for (int b = 0; b < VAL_W; b++) begin
      v[b] = (b < DATA_WIDTH) ? d[b] : 1'b0;
    end
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/ilst_cell.sv]
`default_nettype none
module ilst_cell (
  input  wire logic                clk,
  input  wire ilst_pkg::cell_ctrl_t ctrl,
  input  wire ilst_pkg::data_t      new_data,
  input  wire ilst_pkg::data_t      left_data,
  input  wire ilst_pkg::data_t      right_data,
  output ilst_pkg::data_t           data,
  output ilst_pkg::data_t           rd_data
);
  import ilst_pkg::*;

  data_t data_r;
  data_t data_nxt;

  always_comb begin
    case (ctrl.mode)
      CELL_NEW:   data_nxt = new_data;
      CELL_LEFT:  data_nxt = left_data;
      CELL_RIGHT: data_nxt = right_data;
      default:    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = ctrl.rd_sel ? data_r : '0;

endmodule
`default_nettype wire

[rtl/indexed_list_store.sv]
// Result path: a word taken at an edge with start high and busy low is registered in the s1
//   registers, then in out_word_r (store update, then read reduction); out_valid high for one cycle.
// Throughput: one word per cycle while busy is low; the cell row updates in the accept cycle.
// Reset: synchronous, active low; clears the fill count and the strobes, sets busy_r,
//   which a clock edge with rst_n high clears. The receiver cannot stall.
`default_nettype none
module indexed_list_store (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire ilst_pkg::in_word_t in_word,
  output logic                    out_valid,
  output ilst_pkg::out_word_t     out_word
);
  import ilst_pkg::*;

  logic       busy_r;
  count_t     count_r;
  count_t     count_nxt;
  logic       accept;
  op_t        op;
  cmp_t       pos_c;
  cmp_t       cnt_c;
  logic       in_range;
  logic       not_full;
  logic       not_empty;
  status_t    status_nxt;
  logic       do_app;
  logic       do_pop;
  logic       do_ins;
  logic       do_rem;
  logic       do_rd;
  logic       do_wr;
  data_t      new_data;

  cell_ctrl_t ctrl    [CAPACITY];
  data_t      cell_q  [CAPACITY];
  data_t      cell_rd [CAPACITY];

  logic       s1_valid_r;
  status_t    s1_status_r;
  count_t     s1_count_r;
  data_t      s1_grp_r [NUM_GRP];
  data_t      grp_nxt  [NUM_GRP];
  data_t      rd_nxt;

  logic       out_valid_r;
  out_word_t  out_word_r;

  assign accept   = start && !busy_r;
  assign op       = op_t'(in_word.operation);
  assign pos_c    = CMP_W'(in_word.position);
  assign cnt_c    = CMP_W'(count_r);
  assign in_range = pos_c < cnt_c;
  assign not_full = count_r < CNT_W'(CAPACITY);
  assign not_empty = count_r != '0;
  assign new_data = to_data(in_word.value);

  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = count_r;
    do_app = 1'b0;
    do_pop = 1'b0;
    do_ins = 1'b0;
    do_rem = 1'b0;
    do_rd  = 1'b0;
    do_wr  = 1'b0;
    case (op)
      OP_APPEND: begin
        if (!not_full) status_nxt = ST_FULL;
        else begin
          do_app    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP: begin
        if (!not_empty) status_nxt = ST_EMPTY;
        else begin
          do_pop    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_INSERT: begin
        if (!in_range) status_nxt = ST_RANGE;
        else if (!not_full) status_nxt = ST_FULL;
        else begin
          do_ins    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!in_range) status_nxt = ST_RANGE;
        else begin
          do_rem    = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      OP_READ: begin
        if (!in_range) status_nxt = ST_RANGE;
        else do_rd = 1'b1;
      end
      OP_WRITE: begin
        if (!in_range) status_nxt = ST_RANGE;
        else do_wr = 1'b1;
      end
      OP_CLEAR: count_nxt = '0;
      default: status_nxt = ST_OK;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctrl[i].mode   = CELL_HOLD;
      ctrl[i].rd_sel = 1'b0;
      if (accept) begin
        if ((do_app && CMP_W'(i) == cnt_c) ||
            ((do_ins || do_wr) && CMP_W'(i) == pos_c)) begin
          ctrl[i].mode = CELL_NEW;
        end else if (do_ins && CMP_W'(i) > pos_c && CMP_W'(i) <= cnt_c) begin
          ctrl[i].mode = CELL_LEFT;
        end else if (do_rem && CMP_W'(i) >= pos_c && CMP_W'(i) + 1'b1 < cnt_c) begin
          ctrl[i].mode = CELL_RIGHT;
        end
        ctrl[i].rd_sel = (do_rd && CMP_W'(i) == pos_c) ||
                         (do_pop && CMP_W'(i) + 1'b1 == cnt_c);
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ilst_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .new_data   (new_data),
      .left_data  ((g == 0) ? data_t'('0) : cell_q[(g == 0) ? 0 : g - 1]),
      .right_data ((g == CAPACITY - 1) ? data_t'('0)
                                       : cell_q[(g == CAPACITY - 1) ? g : g + 1]),
      .data       (cell_q[g]),
      .rd_data    (cell_rd[g])
    );
  end

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP_SZ; j++) begin
        if (g * GRP_SZ + j < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * GRP_SZ + j];
        end
      end
    end
  end

  always_comb begin
    rd_nxt = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      rd_nxt = rd_nxt | s1_grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
      if (accept) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status_nxt;
      s1_count_r  <= count_nxt;
      for (int g = 0; g < NUM_GRP; g++) begin
        s1_grp_r[g] <= grp_nxt[g];
      end
    end
    if (s1_valid_r) begin
      out_word_r.read_value <= from_data(rd_nxt);
      out_word_r.status     <= s1_status_r;
      out_word_r.fill_count <= FILL_W'(s1_count_r);
      out_word_r.is_empty   <= (s1_count_r == '0);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

[rtl/ilst_checker.sv]
`default_nettype none
module ilst_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire ilst_pkg::out_word_t out_word
);
  import ilst_pkg::*;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted word");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.is_empty == (out_word.fill_count == '0)))
    else $error("empty flag disagrees with fill count");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status != ST_OK) |-> (out_word.read_value == '0))
    else $error("refused request returned data");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == ST_FULL) |-> (out_word.fill_count == FILL_W'(CAPACITY)))
    else $error("full status below capacity");

endmodule

bind indexed_list_store ilst_checker u_ilst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);
`default_nettype wire

[sim/tb_indexed_list_store.sv]
`timescale 1ns / 100ps
module tb_indexed_list_store;
  import ilst_pkg::*;

  localparam int unsigned LIMIT        = 400000;
  localparam int unsigned RANDOM_WORDS = 500;
  localparam int unsigned QUIET_WORDS  = 60;
  localparam int unsigned DRAIN_CYCLES = 8;

  class list_shadow;
    data_t       cells [CAPACITY];
    int unsigned count;
    out_word_t   expected_words [$];
    int unsigned errors;

    function new();
      count  = 0;
      errors = 0;
      foreach (cells[i]) cells[i] = '0;
    endfunction

    function void note_word(in_word_t w);
      out_word_t   r;
      int unsigned pos;
      int unsigned i;
      data_t       val;
      bit          in_range;
      r        = '0;
      pos      = w.position;
      val      = data_t'(w.value);
      in_range = pos < count;
      case (op_t'(w.operation))
        OP_APPEND: begin
          if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            cells[count] = val;
            count++;
          end
        end
        OP_POP: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            count--;
            r.read_value = VAL_W'(cells[count]);
          end
        end
        OP_INSERT: begin
          if (!in_range) begin
            r.status = ST_RANGE;
          end else if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (i = count; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = val;
            count++;
          end
        end
        OP_REMOVE: begin
          if (!in_range) begin
            r.status = ST_RANGE;
          end else begin
            for (i = pos; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
          end
        end
        OP_READ: begin
          if (!in_range) r.status = ST_RANGE;
          else r.read_value = VAL_W'(cells[pos]);
        end
        OP_WRITE: begin
          if (!in_range) r.status = ST_RANGE;
          else cells[pos] = val;
        end
        OP_CLEAR: begin
          count = 0;
        end
        default: begin
        end
      endcase
      r.fill_count = FILL_W'(count);
      r.is_empty   = (count == 0);
      expected_words = {expected_words, r};
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("result word %h with nothing pending", got));
        return;
      end
      want = expected_words.pop_front();
      if (got.read_value !== want.read_value)
        report($sformatf("read_value exp %h got %h", want.read_value, got.read_value));
      if (got.status !== want.status)
        report($sformatf("status exp %0d got %0d", want.status, got.status));
      if (got.fill_count !== want.fill_count)
        report($sformatf("fill_count exp %0d got %0d", want.fill_count, got.fill_count));
      if (got.is_empty !== want.is_empty)
        report($sformatf("is_empty exp %b got %b", want.is_empty, got.is_empty));
    endtask
  endclass

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;

  list_shadow  shadow;
  int unsigned words_sent = 0;
  int unsigned quiet_mark = 32'hFFFF_FFFF;
  int unsigned idle_pct   = 30;
  int unsigned cycles     = 0;

  indexed_list_store DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("indexed_list_store regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) shadow.check_word(out_word);
  end

  function automatic in_word_t word_of(op_t op, int unsigned pos, logic [VAL_W-1:0] v);
    in_word_t w;
    w.operation = op;
    w.position  = pos[POS_W-1:0];
    w.value     = v;
    return w;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_pos(int unsigned cnt);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (cnt > 0 && roll < 75) return $urandom_range(0, cnt - 1);
    if (cnt > 0 && roll < 82) return cnt - 1;
    if (roll < 90 && cnt < CAPACITY) return cnt;
    return $urandom_range(0, 63);
  endfunction

  function automatic op_t rand_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 24) return OP_APPEND;
    if (roll < 36) return OP_POP;
    if (roll < 52) return OP_INSERT;
    if (roll < 64) return OP_REMOVE;
    if (roll < 79) return OP_READ;
    if (roll < 94) return OP_WRITE;
    if (roll < 97) return OP_CLEAR;
    return OP_NONE;
  endfunction

  task idle(int unsigned n);
    logic [63:0] junk;
    junk    = {$urandom, $urandom};
    start   <= 1'b0;
    in_word <= junk[$bits(in_word_t)-1:0];
    repeat (n) @(posedge clk);
  endtask

  task send(in_word_t w);
    if (words_sent < quiet_mark && $urandom_range(0, 99) < idle_pct)
      idle($urandom_range(1, 13));
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    shadow.note_word(w);
    words_sent++;
  endtask

  task send_op(op_t op);
    send(word_of(op, pick_pos(shadow.count), rand_value()));
  endtask

  initial begin
    int unsigned stop;
    int unsigned target;
    int unsigned n;
    shadow = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send(word_of(OP_POP,    0,  32'h0));
    send(word_of(OP_READ,   0,  32'h0));
    send(word_of(OP_INSERT, 0,  32'hDEAD_BEEF));
    send(word_of(OP_REMOVE, 0,  32'h0));
    send(word_of(OP_WRITE,  0,  32'hFFFF_FFFF));
    send(word_of(OP_NONE,   63, 32'hFFFF_FFFF));
    send(word_of(OP_APPEND, 0,  32'h0000_0000));
    send(word_of(OP_APPEND, 63, 32'hFFFF_FFFF));
    send(word_of(OP_APPEND, 0,  32'hA5A5_A5A5));
    send(word_of(OP_INSERT, 3,  32'h5A5A_5A5A));
    send(word_of(OP_INSERT, 0,  32'h1234_5678));
    send(word_of(OP_INSERT, 2,  32'h8765_4321));
    send(word_of(OP_READ,   0,  32'h0));
    send(word_of(OP_READ,   4,  32'h0));
    send(word_of(OP_READ,   5,  32'h0));
    send(word_of(OP_READ,   63, 32'h0));
    send(word_of(OP_WRITE,  4,  32'hFFFF_FFFF));
    send(word_of(OP_REMOVE, 0,  32'h0));
    send(word_of(OP_REMOVE, 3,  32'h0));
    send(word_of(OP_REMOVE, 63, 32'h0));
    send(word_of(OP_POP,    0,  32'h0));
    send(word_of(OP_NONE,   21, 32'h0F0F_0F0F));
    send(word_of(OP_CLEAR,  0,  32'h0));
    send(word_of(OP_POP,    0,  32'h0));

    stop       = words_sent + RANDOM_WORDS;
    quiet_mark = stop - QUIET_WORDS;
    while (words_sent < stop) begin
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 10;
        default: idle_pct = 40;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          target = $urandom_range(0, 1) ? CAPACITY : $urandom_range(shadow.count, CAPACITY);
          while (shadow.count < target) begin
            if ($urandom_range(0, 99) < 15) send_op(rand_op());
            else send_op(OP_APPEND);
          end
          if (shadow.count == CAPACITY) begin
            send_op(OP_APPEND);
            send_op(OP_INSERT);
            send(word_of(OP_INSERT, 0, rand_value()));
            send(word_of(OP_READ, 63, 32'h0));
            send(word_of(OP_WRITE, 63, rand_value()));
            send(word_of(OP_REMOVE, 63, 32'h0));
          end
        end
        3, 4, 5, 6: begin
          n = $urandom_range(5, 30);
          repeat (n) send_op(rand_op());
        end
        7: begin
          while (shadow.count > 0) begin
            if ($urandom_range(0, 99) < 70) send_op(OP_POP);
            else send(word_of(OP_REMOVE, $urandom_range(0, shadow.count - 1), 32'h0));
          end
          send_op(OP_POP);
          send_op(OP_REMOVE);
        end
        8: begin
          send_op(OP_CLEAR);
          n = $urandom_range(1, 6);
          repeat (n) send_op(OP_APPEND);
        end
        default: begin
          n = $urandom_range(3, 12);
          repeat (n) send(word_of(op_t'($urandom_range(0, 7)), $urandom_range(0, 63), $urandom));
        end
      endcase
    end
    start <= 1'b0;

    while (shadow.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.expected_words.size() != 0)
      shadow.report($sformatf("%0d results never arrived", shadow.expected_words.size()));
    if (shadow.errors == 0) begin
      $display("indexed_list_store regression: pass");
    end else begin
      $display("indexed_list_store regression: fail");
    end
    $finish;
  end

endmodule
